// ----- rtl/nfsa_pkg.sv -----
// shared types and constants for the next-fit slot allocator
`default_nettype none

package nfsa_pkg;

  localparam int SLOT_COUNT_DEFAULT = 64;

  localparam int SLOT_W   = 6;
  localparam int HANDLE_W = 32;
  localparam int FLAGS_W  = 16;

  // slot, handle and flags packed from bit 0, padded to whole bytes
  localparam int FIELDS_W = SLOT_W + HANDLE_W + FLAGS_W;
  localparam int TDATA_W  = ((FIELDS_W + 7) / 8) * 8;
  localparam int PAD_W    = TDATA_W - FIELDS_W;

  typedef enum logic [1:0] {
    OP_ALLOC   = 2'd0,
    OP_RELEASE = 2'd1,
    OP_UPDATE  = 2'd2,
    OP_READ    = 2'd3
  } op_t;

endpackage

`default_nettype wire

// ----- rtl/next_fit_slot_allocator_unit.sv -----
// next-fit slot allocator: slot table memory, scan sequencer and output register
//
// channel   dir  tdata (lsb first)                          tuser
// s_*       in   slot_index, owner_handle, slot_flags, pad  operation
// m_*       out  result_slot, stored_handle, stored_flags   table_full
//
// allocate scans the table from accept to result: the scan reads
// one slot per cycle through the table's single read port, starting at the
// next-fit pointer. release, update and read pass through ST_ACCESS; an
// out-of-range slot goes straight to ST_FINISH. after reset a clearing pass
// zeroes every handle; no word is accepted meanwhile. a result held by m_tready
// stalls the unit before its next result; the next input word may already be taken.
`default_nettype none

module next_fit_slot_allocator_unit
  import nfsa_pkg::*;
#(
  parameter int SLOT_COUNT = SLOT_COUNT_DEFAULT
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               s_tvalid,
  output logic                    s_tready,
  input  wire logic [TDATA_W-1:0] s_tdata,  // slot_index, owner_handle, slot_flags, pad
  input  wire logic [1:0]         s_tuser,  // operation
  output logic                    m_tvalid,
  input  wire logic               m_tready,
  output logic [TDATA_W-1:0]      m_tdata,  // result_slot, stored_handle, stored_flags, pad
  output logic [0:0]              m_tuser   // table_full
);

  localparam int IW = $clog2(SLOT_COUNT);
  localparam logic [IW-1:0] LAST = IW'(SLOT_COUNT - 1);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_ACCESS,
    ST_FINISH
  } state_t;

  state_t state;

  // input word fields
  logic [SLOT_W-1:0]   in_slot;
  logic [HANDLE_W-1:0] in_handle;
  logic [FLAGS_W-1:0]  in_flags;
  op_t                 in_op;
  logic [IW-1:0]       in_idx;
  logic                in_range;
  logic                s_accept;

  assign in_slot   = s_tdata[SLOT_W-1:0];
  assign in_handle = s_tdata[SLOT_W +: HANDLE_W];
  assign in_flags  = s_tdata[SLOT_W+HANDLE_W +: FLAGS_W];
  assign in_op     = op_t'(s_tuser);
  assign in_idx    = IW'(in_slot);
  assign in_range  = 32'(in_slot) < 32'(SLOT_COUNT);
  assign s_tready  = (state == ST_IDLE);
  assign s_accept  = s_tvalid && s_tready;

  // latched request
  op_t                 op_q;
  logic [IW-1:0]       idx_q;
  logic [HANDLE_W-1:0] handle_q;
  logic [FLAGS_W-1:0]  flags_q;

  // sequencer registers
  logic [IW-1:0] ptr;           // scan position, also the clear address
  logic [IW-1:0] seen;          // slots checked in this lap
  logic [IW-1:0] search_start;  // next-fit pointer
  logic [IW-1:0] ptr_inc;

  assign ptr_inc = (ptr == LAST) ? '0 : ptr + IW'(1);

  // result staging
  logic [SLOT_W-1:0]   res_slot;
  logic [HANDLE_W-1:0] res_handle;
  logic [FLAGS_W-1:0]  res_flags;
  logic                res_full;

  // slot table
  logic [HANDLE_W-1:0] handle_mem [SLOT_COUNT];
  logic [FLAGS_W-1:0]  flag_mem   [SLOT_COUNT];
  logic [HANDLE_W-1:0] rd_handle;
  logic [FLAGS_W-1:0]  rd_flags;
  logic                rd_en;
  logic [IW-1:0]       rd_addr;
  logic                wr_en;
  logic                wr_flag_en;
  logic [IW-1:0]       wr_addr;
  logic [HANDLE_W-1:0] wr_handle;
  logic                scan_hit;

  assign scan_hit = (rd_handle == '0);

  always_comb begin
    rd_en      = 1'b0;
    rd_addr    = search_start;
    wr_en      = 1'b0;
    wr_flag_en = 1'b0;
    wr_addr    = ptr;
    wr_handle  = handle_q;
    unique case (state)
      ST_CLEAR: begin
        wr_en     = 1'b1;
        wr_handle = '0;
      end
      ST_IDLE: begin
        rd_en   = s_accept;
        rd_addr = (in_op == OP_ALLOC) ? search_start : in_idx;
      end
      ST_SCAN: begin
        if (scan_hit) begin
          wr_en      = 1'b1;
          wr_flag_en = 1'b1;
        end else begin
          rd_en   = 1'b1;
          rd_addr = ptr_inc;
        end
      end
      ST_ACCESS: begin
        wr_addr   = idx_q;
        wr_en     = (op_q == OP_RELEASE) || (op_q == OP_UPDATE);
        wr_handle = (op_q == OP_RELEASE) ? '0 : handle_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      handle_mem[wr_addr] <= wr_handle;
    end
    if (wr_flag_en) begin
      flag_mem[wr_addr] <= flags_q;
    end
    if (rd_en) begin
      rd_handle <= handle_mem[rd_addr];
      rd_flags  <= flag_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      ptr          <= '0;
      search_start <= '0;
      m_tvalid     <= 1'b0;
    end else begin
      // in ST_FINISH the output register is handled below
      if (m_tvalid && m_tready && state != ST_FINISH) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_CLEAR: begin
          ptr <= ptr_inc;
          if (ptr == LAST) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (s_accept) begin
            op_q     <= in_op;
            idx_q    <= in_idx;
            handle_q <= in_handle;
            flags_q  <= in_flags;
            res_slot <= in_slot;
            res_full <= 1'b0;
            if (in_op == OP_ALLOC) begin
              ptr   <= search_start;
              seen  <= '0;
              state <= ST_SCAN;
            end else if (!in_range) begin
              res_handle <= '0;
              res_flags  <= '0;
              state      <= ST_FINISH;
            end else begin
              state <= ST_ACCESS;
            end
          end
        end
        ST_SCAN: begin
          if (scan_hit) begin
            search_start <= ptr;
            res_slot     <= SLOT_W'(ptr);
            res_handle   <= handle_q;
            res_flags    <= flags_q;
            state        <= ST_FINISH;
          end else if (seen == LAST) begin
            // full lap without a free slot
            res_slot   <= SLOT_W'(search_start);
            res_handle <= '0;
            res_flags  <= '0;
            res_full   <= 1'b1;
            state      <= ST_FINISH;
          end else begin
            ptr  <= ptr_inc;
            seen <= seen + IW'(1);
          end
        end
        ST_ACCESS: begin
          unique case (op_q)
            OP_RELEASE: res_handle <= '0;
            OP_UPDATE:  res_handle <= handle_q;
            default:    res_handle <= rd_handle;
          endcase
          res_flags <= rd_flags;
          state     <= ST_FINISH;
        end
        ST_FINISH: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {PAD_W'(0), res_flags, res_handle, res_slot};
            m_tuser  <= res_full;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // a full result never carries a handle
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[0]) |-> (m_tdata[SLOT_W +: HANDLE_W] == '0))
    else $error("full result with nonzero handle");

  // a hit during the scan leaves the pointer on that slot
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN && scan_hit) |=> (search_start == $past(ptr)))
    else $error("next-fit pointer not moved to allocated slot");

  // the pointer always addresses a slot of the table
  assert property (@(posedge clk) disable iff (rst)
    32'(search_start) < 32'(SLOT_COUNT))
    else $error("next-fit pointer out of range");

  // the clearing pass accepts no word
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR) |-> !s_tready)
    else $error("input taken during clearing pass");

endmodule

`default_nettype wire

// ----- verif/tb_top.sv -----
// self-checking testbench for the next-fit slot allocator unit
`default_nettype none

module tb_top;
  import nfsa_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOT_COUNT  = SLOT_COUNT_DEFAULT;
  localparam int LONG_HOLD   = 400;
  localparam int DRAIN_CYCLES = SLOT_COUNT + 8;
  localparam int RANDOM_WORDS = 1285;
  localparam int PHASE_LEN   = 130;

  typedef struct packed {
    logic [SLOT_W-1:0]   slot;
    logic [HANDLE_W-1:0] handle;
    logic [FLAGS_W-1:0]  flags;
    logic                full;
  } slot_result_t;

  typedef struct packed {
    op_t                 op;
    logic [SLOT_W-1:0]   idx;
    logic [HANDLE_W-1:0] handle;
    logic [FLAGS_W-1:0]  flags;
    logic                typed;
    slot_result_t        want;
  } stim_row_t;

  // directed rows; typed ones carry their result, the rest go through the predictor
  localparam int DIRECTED_ROWS = 15;
  stim_row_t directed_rows [DIRECTED_ROWS] = '{
    '{OP_ALLOC,   6'd63, 32'hFFFF_FFFF, 16'hFFFF, 1'b1, '{6'd0, 32'hFFFF_FFFF, 16'hFFFF, 1'b0}},
    '{OP_ALLOC,   6'd0,  32'h0000_0001, 16'h0000, 1'b1, '{6'd1, 32'h0000_0001, 16'h0000, 1'b0}},
    '{OP_READ,    6'd0,  32'h0000_0000, 16'h0000, 1'b1, '{6'd0, 32'hFFFF_FFFF, 16'hFFFF, 1'b0}},
    '{OP_ALLOC,   6'd5,  32'h0000_0000, 16'h8001, 1'b1, '{6'd2, 32'h0000_0000, 16'h8001, 1'b0}},
    '{OP_ALLOC,   6'd0,  32'hA5A5_A5A5, 16'h5A5A, 1'b1, '{6'd2, 32'hA5A5_A5A5, 16'h5A5A, 1'b0}},
    '{OP_RELEASE, 6'd1,  32'hDEAD_BEEF, 16'hFFFF, 1'b1, '{6'd1, 32'h0000_0000, 16'h0000, 1'b0}},
    '{OP_UPDATE,  6'd1,  32'h1234_5678, 16'hFFFF, 1'b1, '{6'd1, 32'h1234_5678, 16'h0000, 1'b0}},
    '{OP_UPDATE,  6'd1,  32'h0000_0000, 16'h0000, 1'b1, '{6'd1, 32'h0000_0000, 16'h0000, 1'b0}},
    '{OP_READ,    6'd2,  32'hFFFF_FFFF, 16'hFFFF, 1'b1, '{6'd2, 32'hA5A5_A5A5, 16'h5A5A, 1'b0}},
    '{OP_ALLOC,   6'd1,  32'h0000_0080, 16'h0100, 1'b1, '{6'd3, 32'h0000_0080, 16'h0100, 1'b0}},
    '{OP_RELEASE, 6'd0,  32'h0000_0000, 16'h0000, 1'b1, '{6'd0, 32'h0000_0000, 16'hFFFF, 1'b0}},
    '{OP_READ,    6'd1,  32'h0000_0000, 16'h0000, 1'b1, '{6'd1, 32'h0000_0000, 16'h0000, 1'b0}},
    '{OP_ALLOC,   6'd3,  32'h7FFF_FFFF, 16'h7FFF, 1'b1, '{6'd4, 32'h7FFF_FFFF, 16'h7FFF, 1'b0}},
    '{OP_UPDATE,  6'd3,  32'hFFFF_FFFF, 16'hFFFF, 1'b0, '0},
    '{OP_READ,    6'd4,  32'h0000_0000, 16'h0000, 1'b0, '0}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [TDATA_W-1:0] s_tdata = '0;
  logic [1:0] s_tuser = OP_READ;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [TDATA_W-1:0] m_tdata;
  logic [0:0] m_tuser;

  next_fit_slot_allocator_unit #(.SLOT_COUNT(SLOT_COUNT)) dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  always #6 clk = ~clk;

  // predictor state
  logic [HANDLE_W-1:0] owner_tbl [SLOT_COUNT];
  logic [FLAGS_W-1:0]  flag_tbl  [SLOT_COUNT];
  bit                  flags_set [SLOT_COUNT];
  int unsigned         next_fit;

  slot_result_t pending_results [$];
  int mismatches = 0;
  int send_idle_pct = 14;
  int recv_idle_pct = 73;
  int hold_asks = 0;
  int hold_served = 0;
  int hold_left = 0;

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t mismatch: %s got %0h want %0h", $realtime, what, got, want);
    mismatches++;
  endtask

  function automatic slot_result_t predict_slot_op(op_t op, logic [SLOT_W-1:0] idx,
                                                   logic [HANDLE_W-1:0] h,
                                                   logic [FLAGS_W-1:0] f);
    slot_result_t r;
    int unsigned pos;
    bit found;
    r = '0;
    found = 1'b0;
    pos = next_fit;
    if (op == OP_ALLOC) begin
      for (int n = 0; n < SLOT_COUNT && !found; n++) begin
        if (owner_tbl[pos] == '0) found = 1'b1;
        else pos = (pos + 1) % SLOT_COUNT;
      end
      if (found) begin
        owner_tbl[pos] = h;
        flag_tbl[pos] = f;
        flags_set[pos] = 1'b1;
        next_fit = pos;
        r = '{pos[SLOT_W-1:0], h, f, 1'b0};
      end else begin
        // table full: nothing changes
        r.slot = next_fit[SLOT_W-1:0];
        r.full = 1'b1;
      end
    end else begin
      if (op == OP_RELEASE) owner_tbl[idx] = '0;
      else if (op == OP_UPDATE) owner_tbl[idx] = h;
      r = '{idx, owner_tbl[idx], flag_tbl[idx], 1'b0};
    end
    return r;
  endfunction

  // offer one word, wait for the handshake, then record what it should produce
  task automatic send_word(op_t op, logic [SLOT_W-1:0] idx, logic [HANDLE_W-1:0] h,
                           logic [FLAGS_W-1:0] f, bit typed, slot_result_t want);
    slot_result_t r;
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {{PAD_W{1'b0}}, f, h, idx};
    s_tuser <= op;
    do @(posedge clk); while (!s_tready);
    r = predict_slot_op(op, idx, h, f);
    pending_results.push_back(typed ? want : r);
  endtask

  task automatic wait_for_results();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // result checker
  always @(posedge clk) begin
    slot_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result word, slot", m_tdata[SLOT_W-1:0], 0);
      end else begin
        want = pending_results.pop_front();
        if (m_tdata[SLOT_W-1:0] !== want.slot)
          report_mismatch("result_slot", m_tdata[SLOT_W-1:0], want.slot);
        if (m_tdata[SLOT_W+HANDLE_W-1:SLOT_W] !== want.handle)
          report_mismatch("stored_handle", m_tdata[SLOT_W+HANDLE_W-1:SLOT_W], want.handle);
        if (m_tdata[FIELDS_W-1:SLOT_W+HANDLE_W] !== want.flags)
          report_mismatch("stored_flags", m_tdata[FIELDS_W-1:SLOT_W+HANDLE_W], want.flags);
        if (m_tuser[0] !== want.full)
          report_mismatch("table_full", m_tuser[0], want.full);
      end
    end
  end

  // receiver: random stalls plus an occasional long hold-off
  always @(negedge clk) begin
    if (hold_served != hold_asks) begin
      hold_served = hold_asks;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin
    #15_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    op_t op;
    logic [SLOT_W-1:0] idx;
    logic [HANDLE_W-1:0] h;
    logic [FLAGS_W-1:0] f;
    int unsigned roll;
    int unsigned phase;
    int tries;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      owner_tbl[i] = '0;
      flag_tbl[i] = '0;
      flags_set[i] = 1'b0;
    end
    next_fit = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i])
      send_word(directed_rows[i].op, directed_rows[i].idx, directed_rows[i].handle,
                directed_rows[i].flags, directed_rows[i].typed, directed_rows[i].want);
    wait_for_results();

    for (int i = 0; i < RANDOM_WORDS; i++) begin
      if (i == RANDOM_WORDS / 3) begin
        send_idle_pct = 73;
        recv_idle_pct = 14;
      end else if (i == 2 * RANDOM_WORDS / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (i == 200 || i == 1000) hold_asks++;
      if (i % PHASE_LEN == 0 && i != 0) wait_for_results();

      // phases: fill up to full, mixed traffic, drain, hammer a full table
      phase = (i / PHASE_LEN) % 4;
      roll = $urandom_range(99);
      case (phase)
        0: op = (roll < 80) ? OP_ALLOC : (roll < 87) ? OP_READ : (roll < 94) ? OP_UPDATE
                                                                          : OP_RELEASE;
        1: op = (roll < 40) ? OP_ALLOC : (roll < 60) ? OP_RELEASE : (roll < 80) ? OP_UPDATE
                                                                           : OP_READ;
        2: op = (roll < 10) ? OP_ALLOC : (roll < 60) ? OP_RELEASE : (roll < 80) ? OP_UPDATE
                                                                           : OP_READ;
        default: op = (roll < 90) ? OP_ALLOC : OP_READ;
      endcase

      idx = $urandom_range(SLOT_COUNT - 1);
      if (op != OP_ALLOC) begin
        // only touch slots whose flag word has been written; prefer occupied ones
        tries = 0;
        while (!flags_set[idx] || (owner_tbl[idx] == '0 && tries < 6)) begin
          idx = $urandom_range(SLOT_COUNT - 1);
          tries++;
        end
      end

      roll = $urandom_range(99);
      h = (roll < 10) ? 32'h0 : (roll < 15) ? 32'hFFFF_FFFF : $urandom;
      roll = $urandom_range(99);
      f = (roll < 5) ? 16'h0 : (roll < 10) ? 16'hFFFF : 16'($urandom_range(16'hFFFF));

      send_word(op, idx, h, f, 1'b0, '0);
    end

    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

`default_nettype wire

// ----- files.f -----
rtl/nfsa_pkg.sv
rtl/next_fit_slot_allocator_unit.sv
verif/tb_top.sv
